FILE: src/spcm_pkg.sv
// Shared types and codes for the sample playback channel mixer.
// No dependencies.
`timescale 1ns / 1ps
package spcm_pkg;

	typedef enum logic [3:0] {
		FUNC_TICK       = 4'd0,
		FUNC_WRITE      = 4'd1,
		FUNC_SET_SOUND  = 4'd2,
		FUNC_SET_CHAN   = 4'd3,
		FUNC_PLAY       = 4'd4,
		FUNC_PAUSE      = 4'd5,
		FUNC_STOP       = 4'd6,
		FUNC_PAUSE_ALL  = 4'd7,
		FUNC_RESUME_ALL = 4'd8,
		FUNC_STOP_ALL   = 4'd9
	} func_t;

	typedef enum logic [1:0] {
		MODE_STOPPED = 2'd0,
		MODE_PLAYING = 2'd1,
		MODE_PAUSED  = 2'd2
	} mode_t;

	localparam int unsigned LOOP_W  = 13;
	localparam int unsigned FRAC_W  = 16;
	localparam int unsigned SPEED_W = 24;
	localparam int unsigned VOL_W   = 16;
	localparam int unsigned SMP_W   = 16;

endpackage

FILE: src/sample_playback_channel_mixer.sv
// Top level of the multichannel stereo sample player and mixer.
// Depends on spcm_pkg, spcm_ram (sample memory) and spcm_rem (loop wrap).
//
// Channel  | Signals                          | Content
// s_axis   | s_tvalid s_tready s_tdata s_tuser| commands and ticks
// m_axis   | m_tvalid m_tready m_tdata        | mixed stereo sample per tick
// config   | global_volume_wen global_volume  | master gain
//
// A tick walks the channels one at a time through one shared multiplier:
// channels that are not playing are passed over, playing ones are mixed, and
// the remainder unit runs as well for a playing channel whose loop wraps.
// Reset clears all control and channel state; sample memory is not cleared.
// Input is stalled until a tick's result has been handed to the output reg.
`timescale 1ns / 1ps
module sample_playback_channel_mixer #(
	parameter int NUM_CHANNELS      = 16,
	parameter int NUM_SOUNDS        = 8,
	parameter int MAX_SOUND_SAMPLES = 8192
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// channel[3:0] sound[6:4] sample_index[19:7] left_in[35:20] right_in[51:36]
	// sound_length[65:52] loop_start[78:66] loop_end[91:79] loop_flag[92]
	// volume[108:93] speed[132:109], zero pad
	input  logic [135:0] s_tdata,
	// func[3:0]
	input  logic [3:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// left_out[15:0] right_out[31:16]
	output logic [31:0]  m_tdata,
	input  logic         global_volume_wen,
	input  logic [15:0]  global_volume
);

	localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int SND_W  = (NUM_SOUNDS > 1) ? $clog2(NUM_SOUNDS) : 1;
	localparam int IDX_W  = $clog2(MAX_SOUND_SAMPLES);
	localparam int LEN_W  = $clog2(MAX_SOUND_SAMPLES + 1);
	localparam int DEPTH  = NUM_SOUNDS * MAX_SOUND_SAMPLES;
	localparam int AW     = $clog2(DEPTH);
	localparam int POS_W  = IDX_W + 16;
	localparam int CW     = ((POS_W > 29) ? POS_W : 29) + 1;
	localparam int QW     = CW - 16;
	localparam int ACC_W  = 49 + CH_W;
	localparam int MAG_W  = ACC_W - 30;
	localparam int LW     = spcm_pkg::LOOP_W;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_CHAN = 8'b0000_0010,
		ST_GAIN = 8'b0000_0100,
		ST_MULL = 8'b0000_1000,
		ST_MULR = 8'b0001_0000,
		ST_REM  = 8'b0010_0000,
		ST_UPD  = 8'b0100_0000,
		ST_DONE = 8'b1000_0000
	} state_t;

	// input fields
	logic [3:0]  f_channel;
	logic [2:0]  f_sound;
	logic [12:0] f_sidx;
	logic [15:0] f_left, f_right;
	logic [13:0] f_len;
	logic [12:0] f_ls, f_le;
	logic        f_lf;
	logic [15:0] f_vol;
	logic [23:0] f_speed;

	assign f_channel = s_tdata[3:0];
	assign f_sound   = s_tdata[6:4];
	assign f_sidx    = s_tdata[19:7];
	assign f_left    = s_tdata[35:20];
	assign f_right   = s_tdata[51:36];
	assign f_len     = s_tdata[65:52];
	assign f_ls      = s_tdata[78:66];
	assign f_le      = s_tdata[91:79];
	assign f_lf      = s_tdata[92];
	assign f_vol     = s_tdata[108:93];
	assign f_speed   = s_tdata[132:109];

	// state
	state_t              state_q;
	logic [15:0]         gv_q;
	spcm_pkg::mode_t     mode_q  [NUM_CHANNELS];
	logic [SND_W-1:0]    csnd_q  [NUM_CHANNELS];
	logic [15:0]         cvol_q  [NUM_CHANNELS];
	logic [23:0]         cspd_q  [NUM_CHANNELS];
	logic [POS_W-1:0]    cpos_q  [NUM_CHANNELS];
	logic                cloop_q [NUM_CHANNELS];
	logic [LEN_W-1:0]    slen_q  [NUM_SOUNDS];
	logic [LW-1:0]       sls_q   [NUM_SOUNDS];
	logic [LW-1:0]       sle_q   [NUM_SOUNDS];
	logic                sloop_q [NUM_SOUNDS];

	logic [CH_W-1:0]     ch_q;
	logic signed [49:0]  prod_q;
	logic [31:0]         gain_q;
	logic [CW-1:0]       nxt_q;
	logic [CW-1:0]       diff_q;
	logic                wrap_q;
	logic signed [ACC_W-1:0] accl_q, accr_q;
	logic                m_tvalid_q;
	logic [31:0]         m_tdata_q;

	// decode
	logic              accept;
	logic              ch_ok, snd_ok, idx_ok;
	logic [CH_W-1:0]   in_ch;
	logic [SND_W-1:0]  in_snd;
	spcm_pkg::func_t   func;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign func     = spcm_pkg::func_t'(s_tuser);
	assign in_ch    = CH_W'(f_channel);
	assign in_snd   = SND_W'(f_sound);
	assign ch_ok    = int'(f_channel) < NUM_CHANNELS;
	assign snd_ok   = int'(f_sound) < NUM_SOUNDS;
	assign idx_ok   = int'(f_sidx) < MAX_SOUND_SAMPLES;

	// current channel view
	logic [SND_W-1:0] cur_snd;
	logic [POS_W-1:0] cur_pos;
	logic [CW-1:0]    lsf, lef, lenm1f, cand;
	logic [LW-1:0]    cur_ls, cur_le;
	logic [LEN_W-1:0] cur_len;
	logic             stop_ch, last_ch;

	assign cur_snd = csnd_q[ch_q];
	assign cur_pos = cpos_q[ch_q];
	assign cur_ls  = sls_q[cur_snd];
	assign cur_le  = sle_q[cur_snd];
	assign cur_len = slen_q[cur_snd];
	assign lsf     = CW'({cur_ls, 16'b0});
	assign lef     = CW'({cur_le, 16'b0});
	assign lenm1f  = CW'({cur_len - 1'b1, 16'b0});
	assign last_ch = (ch_q == CH_W'(NUM_CHANNELS - 1));

	// sample memory
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [31:0]   ram_rdata;

	assign ram_we    = accept && (func == spcm_pkg::FUNC_WRITE) && snd_ok && idx_ok;
	assign ram_waddr = AW'(int'(in_snd) * MAX_SOUND_SAMPLES + int'(f_sidx));
	assign ram_raddr = AW'(int'(cur_snd) * MAX_SOUND_SAMPLES + int'(cur_pos[POS_W-1:16]));

	spcm_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata ({f_right, f_left}),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// loop wrap remainder
	logic          rem_busy;
	logic [LW-1:0] rem_val;

	spcm_rem #(.QW(QW)) u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     ((state_q == ST_MULL) && wrap_q),
		.dividend  (diff_q[CW-1:16]),
		.divisor   (cur_le - cur_ls),
		.busy      (rem_busy),
		.remainder (rem_val)
	);

	assign cand    = wrap_q ? (lsf + CW'({rem_val, diff_q[15:0]})) : nxt_q;
	assign stop_ch = (cur_len == '0) || (cand > lenm1f);

	// shared multiplier
	logic signed [16:0] mul_a;
	logic signed [32:0] mul_b;

	always_comb begin
		case (state_q)
			ST_GAIN: begin
				mul_a = 17'(signed'(ram_rdata[15:0]));
				mul_b = {1'b0, prod_q[31:0]};
			end
			ST_MULL: begin
				mul_a = 17'(signed'(ram_rdata[31:16]));
				mul_b = {1'b0, gain_q};
			end
			default: begin
				mul_a = {1'b0, gv_q};
				mul_b = {17'b0, cvol_q[ch_q]};
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= 50'(mul_a * mul_b);
		if (state_q == ST_GAIN) begin
			gain_q <= prod_q[31:0];
			wrap_q <= cloop_q[ch_q] && (cur_le > cur_ls) && (CW'(cur_pos) <= lef)
				&& (nxt_q > lef);
			diff_q <= nxt_q - lsf;
		end
		if (state_q == ST_CHAN) begin
			nxt_q <= CW'(cur_pos) + CW'(cspd_q[ch_q]);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ch_q    <= '0;
			accl_q  <= '0;
			accr_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && func == spcm_pkg::FUNC_TICK) begin
						state_q <= ST_CHAN;
						ch_q    <= '0;
						accl_q  <= '0;
						accr_q  <= '0;
					end
				end
				ST_CHAN: begin
					if (mode_q[ch_q] == spcm_pkg::MODE_PLAYING) begin
						state_q <= ST_GAIN;
					end else if (last_ch) begin
						state_q <= ST_DONE;
					end else begin
						ch_q <= ch_q + 1'b1;
					end
				end
				ST_GAIN: state_q <= ST_MULL;
				ST_MULL: begin
					accl_q  <= accl_q + ACC_W'(prod_q);
					state_q <= ST_MULR;
				end
				ST_MULR: begin
					accr_q  <= accr_q + ACC_W'(prod_q);
					state_q <= wrap_q ? ST_REM : ST_UPD;
				end
				ST_REM: begin
					if (!rem_busy) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (last_ch) begin
						state_q <= ST_DONE;
					end else begin
						ch_q    <= ch_q + 1'b1;
						state_q <= ST_CHAN;
					end
				end
				ST_DONE: begin
					if (!m_tvalid_q) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// config and channel/sound tables
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gv_q <= 16'd32768;
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				mode_q[c]  <= spcm_pkg::MODE_STOPPED;
				csnd_q[c]  <= '0;
				cvol_q[c]  <= 16'd16384;
				cspd_q[c]  <= 24'd65536;
				cpos_q[c]  <= '0;
				cloop_q[c] <= 1'b0;
			end
			for (int s = 0; s < NUM_SOUNDS; s++) begin
				slen_q[s]  <= '0;
				sls_q[s]   <= '0;
				sle_q[s]   <= '0;
				sloop_q[s] <= 1'b0;
			end
		end else begin
			if (global_volume_wen) begin
				gv_q <= global_volume;
			end
			if (state_q == ST_UPD) begin
				if (stop_ch) begin
					mode_q[ch_q] <= spcm_pkg::MODE_STOPPED;
					cpos_q[ch_q] <= '0;
				end else begin
					cpos_q[ch_q] <= cand[POS_W-1:0];
				end
			end
			if (accept) begin
				case (func)
					spcm_pkg::FUNC_SET_SOUND: begin
						if (snd_ok) begin
							slen_q[in_snd]  <= (int'(f_len) > MAX_SOUND_SAMPLES) ?
								LEN_W'(MAX_SOUND_SAMPLES) : LEN_W'(f_len);
							sls_q[in_snd]   <= f_ls;
							sle_q[in_snd]   <= f_le;
							sloop_q[in_snd] <= f_lf;
						end
					end
					spcm_pkg::FUNC_SET_CHAN: begin
						if (ch_ok && snd_ok) begin
							csnd_q[in_ch]  <= in_snd;
							cvol_q[in_ch]  <= f_vol;
							cspd_q[in_ch]  <= f_speed;
							cloop_q[in_ch] <= f_lf;
						end
					end
					spcm_pkg::FUNC_PLAY: begin
						if (ch_ok) begin
							if (mode_q[in_ch] != spcm_pkg::MODE_PAUSED) begin
								cpos_q[in_ch]  <= '0;
								cloop_q[in_ch] <= sloop_q[csnd_q[in_ch]];
							end
							mode_q[in_ch] <= spcm_pkg::MODE_PLAYING;
						end
					end
					spcm_pkg::FUNC_PAUSE: begin
						if (ch_ok) begin
							mode_q[in_ch] <= spcm_pkg::MODE_PAUSED;
						end
					end
					spcm_pkg::FUNC_STOP: begin
						if (ch_ok) begin
							mode_q[in_ch] <= spcm_pkg::MODE_STOPPED;
							cpos_q[in_ch] <= '0;
						end
					end
					spcm_pkg::FUNC_PAUSE_ALL: begin
						for (int c = 0; c < NUM_CHANNELS; c++) begin
							if (mode_q[c] == spcm_pkg::MODE_PLAYING) begin
								mode_q[c] <= spcm_pkg::MODE_PAUSED;
							end
						end
					end
					spcm_pkg::FUNC_RESUME_ALL: begin
						for (int c = 0; c < NUM_CHANNELS; c++) begin
							if (mode_q[c] == spcm_pkg::MODE_PAUSED) begin
								mode_q[c] <= spcm_pkg::MODE_PLAYING;
							end
						end
					end
					spcm_pkg::FUNC_STOP_ALL: begin
						for (int c = 0; c < NUM_CHANNELS; c++) begin
							if (mode_q[c] != spcm_pkg::MODE_STOPPED) begin
								mode_q[c] <= spcm_pkg::MODE_STOPPED;
								cpos_q[c] <= '0;
							end
						end
					end
					default: ;
				endcase
			end
		end
	end

	// output: truncate toward zero, saturate
	function automatic logic [15:0] to_out(input logic signed [ACC_W-1:0] acc);
		logic [ACC_W-1:0] mag_full;
		logic [MAG_W-1:0] mag;
		logic [15:0]      res;
		mag_full = acc[ACC_W-1] ? (~acc + 1'b1) : acc;
		mag      = mag_full[ACC_W-1:30];
		if (acc[ACC_W-1]) begin
			res = (mag > MAG_W'(32768)) ? 16'h8000 : 16'(~mag + 1'b1);
		end else begin
			res = (mag > MAG_W'(32767)) ? 16'h7FFF : mag[15:0];
		end
		return res;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_DONE && !m_tvalid_q) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && !m_tvalid_q) begin
			m_tdata_q <= {to_out(accr_q), to_out(accl_q)};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef SYNTH
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> state_q == ST_IDLE) else $error("ready outside idle");
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q)) else $error("state not one-hot");
	a_rem_window: assert property (@(posedge clk) disable iff (!arst_n)
		rem_busy |-> (state_q == ST_MULR || state_q == ST_REM))
		else $error("remainder unit busy outside wrap");
	a_done_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !m_tvalid_q) |=> (m_tvalid_q && state_q == ST_IDLE))
		else $error("tick result not issued");
`endif

endmodule

FILE: src/spcm_ram.sv
// Generic single-port-write, registered-read RAM.
// No dependencies.
`timescale 1ns / 1ps
module spcm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: src/spcm_rem.sv
// Iterative restoring remainder unit, one dividend bit per cycle.
// Uses spcm_pkg for the loop index width.
`timescale 1ns / 1ps
module spcm_rem #(
	parameter int QW = 14
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [QW-1:0]                   dividend,
	input  logic [spcm_pkg::LOOP_W-1:0]     divisor,
	output logic                            busy,
	output logic [spcm_pkg::LOOP_W-1:0]     remainder
);

	localparam int LW = spcm_pkg::LOOP_W;
	localparam int CNT_W = $clog2(QW + 1);

	logic [QW-1:0]    dvd_q;
	logic [LW-1:0]    dsr_q;
	logic [LW-1:0]    rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [LW:0]      trial;

	assign trial = {rem_q, dvd_q[QW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(QW);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 1'b1;
			busy_q <= (cnt_q != CNT_W'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			if (trial >= {1'b0, dsr_q}) begin
				rem_q <= LW'(trial - {1'b0, dsr_q});
			end else begin
				rem_q <= trial[LW-1:0];
			end
		end
	end

	assign busy      = busy_q;
	assign remainder = rem_q;

endmodule
